>>> sv/ldm_pkg.sv
// Types, constants and helpers shared by the lens distortion map modules.
`default_nettype none
package ldm_pkg;

	localparam int PADDR_W    = 6;
	localparam int SUB_W      = 4;
	localparam int LENS_STEPS = 15;
	localparam int DIST_STEPS = 5;

	localparam logic signed [63:0] Q28_ONE = 64'sd268435456;
	localparam logic signed [31:0] RAD_EPS = 32'sd27;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FOCAL = 2'd1;
	localparam logic [1:0] ST_SING  = 2'd2;
	localparam logic [1:0] ST_SAT   = 2'd3;

	localparam logic [2:0] REG_FOCAL  = 3'd0;
	localparam logic [2:0] REG_CENTRE = 3'd1;
	localparam logic [2:0] REG_SKEW   = 3'd2;
	localparam logic [2:0] REG_K1     = 3'd3;
	localparam logic [2:0] REG_K2     = 3'd4;
	localparam logic [2:0] REG_K3     = 3'd5;
	localparam logic [2:0] REG_P1     = 3'd6;
	localparam logic [2:0] REG_P2     = 3'd7;

	typedef enum logic [5:0] {
		OP_NONE, OP_LOAD, OP_FOCAL,
		OP_DIVY_GO, OP_DIVY_WR, OP_DIVX_GO, OP_DIVX_WR, OP_SKEW,
		OP_L_XX, OP_L_YY, OP_L_XY, OP_L_R2, OP_L_R4, OP_L_R6, OP_L_TX, OP_L_TY,
		OP_L_RAD1, OP_L_RAD2, OP_L_RAD3, OP_L_DX1, OP_L_DX2, OP_L_DY1, OP_L_DY2,
		OP_NX_GO, OP_NX_WR, OP_NY_GO, OP_NY_WR, OP_SING,
		OP_D_XD, OP_D_YD, OP_D_S, OP_D_PX, OP_D_PY, OP_OUT
	} op_t;

	typedef struct packed {
		logic [31:0]        fx;
		logic [31:0]        fy;
		logic signed [31:0] cx;
		logic signed [31:0] cy;
		logic signed [31:0] skew;
		logic signed [31:0] k1;
		logic signed [31:0] k2;
		logic signed [31:0] k3;
		logic signed [31:0] p1;
		logic signed [31:0] p2;
	} cfg_t;

	typedef struct packed {
		op_t op;
	} cmd_t;

	typedef struct packed {
		logic func;
		logic focal_zero;
		logic rad_small;
		logic div_done;
	} sts_t;

	function automatic logic ovf32(input logic signed [63:0] v);
		return v != 64'(signed'(v[31:0]));
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		if (!ovf32(v))
			return v[31:0];
		return v[63] ? 32'sh8000_0000 : 32'sh7fff_ffff;
	endfunction

	function automatic op_t lens_op(input logic [SUB_W-1:0] idx);
		op_t o;
		case (idx)
			4'd0: o = OP_L_XX;
			4'd1: o = OP_L_YY;
			4'd2: o = OP_L_XY;
			4'd3: o = OP_L_R2;
			4'd4: o = OP_L_R4;
			4'd5: o = OP_L_R6;
			4'd6: o = OP_L_TX;
			4'd7: o = OP_L_TY;
			4'd8: o = OP_L_RAD1;
			4'd9: o = OP_L_RAD2;
			4'd10: o = OP_L_RAD3;
			4'd11: o = OP_L_DX1;
			4'd12: o = OP_L_DX2;
			4'd13: o = OP_L_DY1;
			4'd14: o = OP_L_DY2;
			default: o = OP_NONE;
		endcase
		return o;
	endfunction

	function automatic op_t dist_op(input logic [SUB_W-1:0] idx);
		op_t o;
		case (idx)
			4'd0: o = OP_D_XD;
			4'd1: o = OP_D_YD;
			4'd2: o = OP_D_S;
			4'd3: o = OP_D_PX;
			4'd4: o = OP_D_PY;
			default: o = OP_NONE;
		endcase
		return o;
	endfunction

endpackage
`default_nettype wire

>>> sv/ldm_div.sv
// Radix-2 restoring signed divider, 64-bit dividend, truncating quotient.
`default_nettype none
module ldm_div (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire logic signed [63:0] num,
	input  wire logic signed [32:0] den,
	output logic                    done,
	output logic signed [63:0]      quot
);

	logic [63:0] quo_q;
	logic [32:0] rem_q;
	logic [32:0] den_q;
	logic        neg_q;
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [33:0] shifted;
	logic [34:0] trial;

	assign shifted = {rem_q, quo_q[63]};
	assign trial   = {1'b0, shifted} - {2'b00, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 6'd1;
			if (cnt_q == 6'd63) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= num[63] ? (~num + 64'd1) : num;
			den_q <= den[32] ? (~den + 33'd1) : den;
			rem_q <= '0;
			neg_q <= num[63] ^ den[32];
		end else if (busy_q) begin
			quo_q <= {quo_q[62:0], ~trial[34]};
			rem_q <= trial[34] ? shifted[32:0] : trial[32:0];
		end
	end

	assign done = done_q;
	assign quot = neg_q ? -signed'(quo_q) : signed'(quo_q);

endmodule
`default_nettype wire

>>> sv/ldm_dp.sv
// Datapath: shared multiplier, adder, saturation, divider and result registers.
`default_nettype none
module ldm_dp (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire ldm_pkg::cfg_t      cfg,
	input  wire ldm_pkg::cmd_t      cmd,
	output ldm_pkg::sts_t           sts,
	input  wire logic               func,
	input  wire logic signed [31:0] in_x,
	input  wire logic signed [31:0] in_y,
	output logic signed [31:0]      out_x,
	output logic signed [31:0]      out_y,
	output logic [1:0]              status
);

	logic               func_q;
	logic signed [31:0] ix_q, iy_q, x_q, y_q, x0_q, y0_q;
	logic signed [35:0] xx_q, yy_q;
	logic signed [31:0] xy_q, r2_q, r4_q, r6_q, tx_q, ty_q, rad_q, dx_q, dy_q;
	logic signed [47:0] acc_q;
	logic signed [63:0] xq_q;
	logic               sat_q, focal_q, sing_q;
	logic signed [31:0] ox_q, oy_q;
	logic [1:0]         ost_q;

	logic signed [32:0] ma, mb;
	logic signed [65:0] prod;
	logic signed [63:0] p28, p24, sum, sum2;
	logic signed [63:0] div_num;
	logic signed [32:0] div_den;
	logic signed [63:0] quot;
	logic               div_start, div_done;
	logic signed [32:0] dcy, dcx;
	logic signed [31:0] nsat;

	assign prod = ma * mb;
	assign p28  = 64'(prod >>> 28);
	assign p24  = 64'(prod >>> 24);
	assign dcy  = 33'(iy_q) - 33'(cfg.cy);
	assign dcx  = 33'(ix_q) - 33'(cfg.cx);

	always_comb begin
		ma = '0;
		mb = '0;
		case (cmd.op)
			ldm_pkg::OP_L_XX:   begin ma = 33'(x_q);  mb = 33'(x_q);  end
			ldm_pkg::OP_L_YY:   begin ma = 33'(y_q);  mb = 33'(y_q);  end
			ldm_pkg::OP_L_XY:   begin ma = 33'(x_q);  mb = 33'(y_q);  end
			ldm_pkg::OP_L_R4:   begin ma = 33'(r2_q); mb = 33'(r2_q); end
			ldm_pkg::OP_L_R6:   begin ma = 33'(r4_q); mb = 33'(r2_q); end
			ldm_pkg::OP_L_RAD1: begin ma = 33'(cfg.k1); mb = 33'(r2_q); end
			ldm_pkg::OP_L_RAD2: begin ma = 33'(cfg.k2); mb = 33'(r4_q); end
			ldm_pkg::OP_L_RAD3: begin ma = 33'(cfg.k3); mb = 33'(r6_q); end
			ldm_pkg::OP_L_DX1:  begin ma = 33'(cfg.p1); mb = 33'(xy_q); end
			ldm_pkg::OP_L_DX2:  begin ma = 33'(cfg.p2); mb = 33'(tx_q); end
			ldm_pkg::OP_L_DY1:  begin ma = 33'(cfg.p1); mb = 33'(ty_q); end
			ldm_pkg::OP_L_DY2:  begin ma = 33'(cfg.p2); mb = 33'(xy_q); end
			ldm_pkg::OP_SKEW:   begin ma = 33'(cfg.skew); mb = 33'(y_q); end
			ldm_pkg::OP_D_XD:   begin ma = 33'(x_q); mb = 33'(rad_q); end
			ldm_pkg::OP_D_YD:   begin ma = 33'(y_q); mb = 33'(rad_q); end
			ldm_pkg::OP_D_S:    begin ma = 33'(cfg.skew); mb = 33'(y_q); end
			ldm_pkg::OP_D_PX:   begin ma = {1'b0, cfg.fx}; mb = 33'(x_q); end
			ldm_pkg::OP_D_PY:   begin ma = {1'b0, cfg.fy}; mb = 33'(y_q); end
			default:   begin ma = '0; mb = '0; end
		endcase
	end

	always_comb begin
		sum = '0;
		sum2 = 64'(dcy);
		case (cmd.op)
			ldm_pkg::OP_L_XX, ldm_pkg::OP_L_YY, ldm_pkg::OP_L_XY, ldm_pkg::OP_L_R4,
			ldm_pkg::OP_L_R6: sum = p28;
			ldm_pkg::OP_L_R2:   sum = 64'(xx_q) + 64'(yy_q);
			ldm_pkg::OP_L_TX:   sum = 64'(r2_q) + (64'(xx_q) <<< 1);
			ldm_pkg::OP_L_TY:   sum = 64'(r2_q) + (64'(yy_q) <<< 1);
			ldm_pkg::OP_L_RAD1: sum = ldm_pkg::Q28_ONE + p24;
			ldm_pkg::OP_L_RAD2, ldm_pkg::OP_L_RAD3, ldm_pkg::OP_L_DX2: sum = 64'(acc_q) + p24;
			ldm_pkg::OP_L_DX1:  sum = p24 <<< 1;
			ldm_pkg::OP_L_DY1:  sum = p24;
			ldm_pkg::OP_L_DY2:  sum = 64'(acc_q) + (p24 <<< 1);
			ldm_pkg::OP_NX_GO:  sum = 64'(x0_q) - 64'(dx_q);
			ldm_pkg::OP_NY_GO:  sum = 64'(y0_q) - 64'(dy_q);
			ldm_pkg::OP_NX_WR, ldm_pkg::OP_NY_WR, ldm_pkg::OP_DIVY_WR,
			ldm_pkg::OP_DIVX_WR: sum = quot;
			ldm_pkg::OP_SKEW:   sum = xq_q - p24;
			ldm_pkg::OP_D_XD:   sum = p28 + 64'(dx_q);
			ldm_pkg::OP_D_YD:   sum = p28 + 64'(dy_q);
			ldm_pkg::OP_D_S:    sum = 64'(x_q) + p24;
			ldm_pkg::OP_D_PX:   sum = p28 + 64'(cfg.cx);
			ldm_pkg::OP_D_PY:   sum = p28 + 64'(cfg.cy);
			ldm_pkg::OP_FOCAL:  sum = 64'(dcx);
			default:   sum = '0;
		endcase
	end

	assign nsat = ldm_pkg::sat32(sum);

	always_comb begin
		div_start = 1'b1;
		div_num   = {{3{dcy[32]}}, dcy, 28'b0};
		div_den   = {1'b0, cfg.fy};
		case (cmd.op)
			ldm_pkg::OP_DIVY_GO: begin
				div_num = {{3{dcy[32]}}, dcy, 28'b0};
				div_den = {1'b0, cfg.fy};
			end
			ldm_pkg::OP_DIVX_GO: begin
				div_num = {{3{dcx[32]}}, dcx, 28'b0};
				div_den = {1'b0, cfg.fx};
			end
			ldm_pkg::OP_NX_GO, ldm_pkg::OP_NY_GO: begin
				div_num = {{4{nsat[31]}}, nsat, 28'b0};
				div_den = 33'(rad_q);
			end
			default: div_start = 1'b0;
		endcase
	end

	ldm_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quot   (quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sat_q   <= 1'b0;
			focal_q <= 1'b0;
			sing_q  <= 1'b0;
		end else begin
			case (cmd.op)
				ldm_pkg::OP_LOAD: begin
					sat_q   <= 1'b0;
					focal_q <= 1'b0;
					sing_q  <= 1'b0;
				end
				ldm_pkg::OP_FOCAL: focal_q <= 1'b1;
				ldm_pkg::OP_SING:  sing_q  <= 1'b1;
				ldm_pkg::OP_L_XY, ldm_pkg::OP_L_R2, ldm_pkg::OP_L_R4, ldm_pkg::OP_L_R6,
				ldm_pkg::OP_L_TX, ldm_pkg::OP_L_TY, ldm_pkg::OP_L_RAD3,
				ldm_pkg::OP_L_DX2, ldm_pkg::OP_L_DY2, ldm_pkg::OP_NX_GO, ldm_pkg::OP_NY_GO,
				ldm_pkg::OP_NX_WR, ldm_pkg::OP_NY_WR, ldm_pkg::OP_DIVY_WR, ldm_pkg::OP_SKEW,
				ldm_pkg::OP_D_XD, ldm_pkg::OP_D_YD, ldm_pkg::OP_D_S, ldm_pkg::OP_D_PX,
				ldm_pkg::OP_D_PY:
					sat_q <= sat_q | ldm_pkg::ovf32(sum);
				default: sat_q <= sat_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			ldm_pkg::OP_LOAD: begin
				func_q <= func;
				ix_q   <= in_x;
				iy_q   <= in_y;
				x_q    <= in_x;
				y_q    <= in_y;
			end
			ldm_pkg::OP_FOCAL: begin
				x_q <= nsat;
				y_q <= ldm_pkg::sat32(sum2);
			end
			ldm_pkg::OP_DIVY_WR: begin
				y_q  <= nsat;
				y0_q <= nsat;
			end
			ldm_pkg::OP_DIVX_WR: xq_q <= sum;
			ldm_pkg::OP_SKEW: begin
				x_q  <= nsat;
				x0_q <= nsat;
			end
			ldm_pkg::OP_L_XX:   xx_q <= 36'(sum);
			ldm_pkg::OP_L_YY:   yy_q <= 36'(sum);
			ldm_pkg::OP_L_XY:   xy_q <= nsat;
			ldm_pkg::OP_L_R2:   r2_q <= nsat;
			ldm_pkg::OP_L_R4:   r4_q <= nsat;
			ldm_pkg::OP_L_R6:   r6_q <= nsat;
			ldm_pkg::OP_L_TX:   tx_q <= nsat;
			ldm_pkg::OP_L_TY:   ty_q <= nsat;
			ldm_pkg::OP_L_RAD1, ldm_pkg::OP_L_RAD2, ldm_pkg::OP_L_DX1,
			ldm_pkg::OP_L_DY1: acc_q <= 48'(sum);
			ldm_pkg::OP_L_RAD3: rad_q <= nsat;
			ldm_pkg::OP_L_DX2:  dx_q <= nsat;
			ldm_pkg::OP_L_DY2:  dy_q <= nsat;
			ldm_pkg::OP_NX_WR, ldm_pkg::OP_D_XD, ldm_pkg::OP_D_S,
			ldm_pkg::OP_D_PX: x_q <= nsat;
			ldm_pkg::OP_NY_WR, ldm_pkg::OP_D_YD, ldm_pkg::OP_D_PY: y_q <= nsat;
			ldm_pkg::OP_OUT: begin
				ox_q <= x_q;
				oy_q <= y_q;
				if (focal_q)
					ost_q <= ldm_pkg::ST_FOCAL;
				else if (sing_q)
					ost_q <= ldm_pkg::ST_SING;
				else if (sat_q)
					ost_q <= ldm_pkg::ST_SAT;
				else
					ost_q <= ldm_pkg::ST_OK;
			end
			default: ;
		endcase
	end

	assign sts.func       = func_q;
	assign sts.focal_zero = (cfg.fx == 32'd0) || (cfg.fy == 32'd0);
	assign sts.rad_small  = (rad_q > -ldm_pkg::RAD_EPS) && (rad_q < ldm_pkg::RAD_EPS);
	assign sts.div_done   = div_done;

	assign out_x  = ox_q;
	assign out_y  = oy_q;
	assign status = ost_q;

endmodule
`default_nettype wire

>>> sv/ldm_ctrl.sv
// Controller: sequences the datapath operations and runs the beat handshakes.
`default_nettype none
module ldm_ctrl #(
	parameter int ITERATIONS = 20
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  wire logic          out_ready,
	input  wire ldm_pkg::sts_t sts,
	output ldm_pkg::cmd_t      cmd
);

	localparam int ITW = (ITERATIONS > 1) ? $clog2(ITERATIONS) : 1;

	typedef enum logic [10:0] {
		S_IDLE  = 11'b000_0000_0001,
		S_START = 11'b000_0000_0010,
		S_DIVY  = 11'b000_0000_0100,
		S_DIVX  = 11'b000_0000_1000,
		S_SKEW  = 11'b000_0001_0000,
		S_LENS  = 11'b000_0010_0000,
		S_TEST  = 11'b000_0100_0000,
		S_NX    = 11'b000_1000_0000,
		S_NY    = 11'b001_0000_0000,
		S_DIST  = 11'b010_0000_0000,
		S_FIN   = 11'b100_0000_0000
	} state_t;

	state_t                     state_q, state_n;
	logic [ldm_pkg::SUB_W-1:0]  sub_q, sub_n;
	logic [ITW-1:0]             iter_q, iter_n;
	logic                       go_q, go_n;
	logic                       out_valid_q;
	ldm_pkg::op_t               op;

	always_comb begin
		state_n = state_q;
		sub_n   = sub_q;
		iter_n  = iter_q;
		go_n    = go_q;
		op      = ldm_pkg::OP_NONE;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					op      = ldm_pkg::OP_LOAD;
					state_n = S_START;
				end
			end
			S_START: begin
				sub_n = '0;
				go_n  = 1'b0;
				if (sts.func)
					state_n = S_LENS;
				else if (sts.focal_zero) begin
					op      = ldm_pkg::OP_FOCAL;
					state_n = S_FIN;
				end else
					state_n = S_DIVY;
			end
			S_DIVY: begin
				if (!go_q) begin
					op   = ldm_pkg::OP_DIVY_GO;
					go_n = 1'b1;
				end else if (sts.div_done) begin
					op      = ldm_pkg::OP_DIVY_WR;
					go_n    = 1'b0;
					state_n = S_DIVX;
				end
			end
			S_DIVX: begin
				if (!go_q) begin
					op   = ldm_pkg::OP_DIVX_GO;
					go_n = 1'b1;
				end else if (sts.div_done) begin
					op      = ldm_pkg::OP_DIVX_WR;
					go_n    = 1'b0;
					state_n = S_SKEW;
				end
			end
			S_SKEW: begin
				op      = ldm_pkg::OP_SKEW;
				iter_n  = '0;
				sub_n   = '0;
				state_n = S_LENS;
			end
			S_LENS: begin
				op = ldm_pkg::lens_op(sub_q);
				if (sub_q == ldm_pkg::SUB_W'(ldm_pkg::LENS_STEPS - 1)) begin
					sub_n   = '0;
					state_n = sts.func ? S_DIST : S_TEST;
				end else
					sub_n = sub_q + 1'b1;
			end
			S_TEST: begin
				go_n = 1'b0;
				if (sts.rad_small) begin
					op      = ldm_pkg::OP_SING;
					state_n = S_FIN;
				end else
					state_n = S_NX;
			end
			S_NX: begin
				if (!go_q) begin
					op   = ldm_pkg::OP_NX_GO;
					go_n = 1'b1;
				end else if (sts.div_done) begin
					op      = ldm_pkg::OP_NX_WR;
					go_n    = 1'b0;
					state_n = S_NY;
				end
			end
			S_NY: begin
				if (!go_q) begin
					op   = ldm_pkg::OP_NY_GO;
					go_n = 1'b1;
				end else if (sts.div_done) begin
					op    = ldm_pkg::OP_NY_WR;
					go_n  = 1'b0;
					sub_n = '0;
					if (iter_q == ITW'(ITERATIONS - 1))
						state_n = S_FIN;
					else begin
						iter_n  = iter_q + 1'b1;
						state_n = S_LENS;
					end
				end
			end
			S_DIST: begin
				op = ldm_pkg::dist_op(sub_q);
				if (sub_q == ldm_pkg::SUB_W'(ldm_pkg::DIST_STEPS - 1)) begin
					sub_n   = '0;
					state_n = S_FIN;
				end else
					sub_n = sub_q + 1'b1;
			end
			S_FIN: begin
				if (!out_valid_q || out_ready) begin
					op      = ldm_pkg::OP_OUT;
					state_n = S_IDLE;
				end
			end
			default: state_n = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			sub_q       <= '0;
			iter_q      <= '0;
			go_q        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			sub_q   <= sub_n;
			iter_q  <= iter_n;
			go_q    <= go_n;
			if (op == ldm_pkg::OP_OUT)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign cmd.op    = op;

endmodule
`default_nettype wire

>>> sv/lens_distortion_map.sv
// Each undistort pass is bounded by two bit-serial divisions through the one divider.
// A zero focal length on undistort goes straight to the result without dividing.
// The block takes a new beat only after the last one has finished; a new beat enters while a result waits.
// Reset: asynchronous, active low; registers that have a reset take their reset values, the block idles.
`default_nettype none
module lens_distortion_map #(
	parameter int ITERATIONS = 20
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [ldm_pkg::PADDR_W-1:0]  paddr,
	input  wire logic [63:0]                  pwdata,
	output logic [63:0]                       prdata,
	output logic                              pready,
	input  wire logic                         in_valid,
	output logic                              in_ready,
	input  wire logic                         func,
	input  wire logic signed [31:0]           in_x,
	input  wire logic signed [31:0]           in_y,
	output logic                              out_valid,
	input  wire logic                         out_ready,
	output logic signed [31:0]                out_x,
	output logic signed [31:0]                out_y,
	output logic [1:0]                        status
);

	ldm_pkg::cfg_t cfg_q;
	ldm_pkg::cmd_t cmd;
	ldm_pkg::sts_t sts;
	logic [2:0]    ridx;

	assign ridx   = paddr[5:3];
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.fx   <= 32'h0001_0000;
			cfg_q.fy   <= 32'h0001_0000;
			cfg_q.cx   <= '0;
			cfg_q.cy   <= '0;
			cfg_q.skew <= '0;
			cfg_q.k1   <= '0;
			cfg_q.k2   <= '0;
			cfg_q.k3   <= '0;
			cfg_q.p1   <= '0;
			cfg_q.p2   <= '0;
		end else if (psel && penable && pwrite) begin
			case (ridx)
				ldm_pkg::REG_FOCAL: begin
					cfg_q.fx <= pwdata[63:32];
					cfg_q.fy <= pwdata[31:0];
				end
				ldm_pkg::REG_CENTRE: begin
					cfg_q.cx <= pwdata[63:32];
					cfg_q.cy <= pwdata[31:0];
				end
				ldm_pkg::REG_SKEW: cfg_q.skew <= pwdata[31:0];
				ldm_pkg::REG_K1:   cfg_q.k1   <= pwdata[31:0];
				ldm_pkg::REG_K2:   cfg_q.k2   <= pwdata[31:0];
				ldm_pkg::REG_K3:   cfg_q.k3   <= pwdata[31:0];
				ldm_pkg::REG_P1:   cfg_q.p1   <= pwdata[31:0];
				ldm_pkg::REG_P2:   cfg_q.p2   <= pwdata[31:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (ridx)
			ldm_pkg::REG_FOCAL:  prdata = {cfg_q.fx, cfg_q.fy};
			ldm_pkg::REG_CENTRE: prdata = {cfg_q.cx, cfg_q.cy};
			ldm_pkg::REG_SKEW:   prdata = {32'd0, cfg_q.skew};
			ldm_pkg::REG_K1:     prdata = {32'd0, cfg_q.k1};
			ldm_pkg::REG_K2:     prdata = {32'd0, cfg_q.k2};
			ldm_pkg::REG_K3:     prdata = {32'd0, cfg_q.k3};
			ldm_pkg::REG_P1:     prdata = {32'd0, cfg_q.p1};
			ldm_pkg::REG_P2:     prdata = {32'd0, cfg_q.p2};
			default:             prdata = '0;
		endcase
	end

	ldm_ctrl #(
		.ITERATIONS (ITERATIONS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	ldm_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.cmd    (cmd),
		.sts    (sts),
		.func   (func),
		.in_x   (in_x),
		.in_y   (in_y),
		.out_x  (out_x),
		.out_y  (out_y),
		.status (status)
	);

endmodule
`default_nettype wire

>>> dv/tb_lens_distortion_map.sv
// Self-checking testbench for lens_distortion_map: directed table and random beats against a predictor.
`timescale 1ns / 100ps
`default_nettype none
module tb_lens_distortion_map;

	localparam longint S32_HI    = 64'sd2147483647;
	localparam longint S32_LO    = -64'sd2147483648;
	localparam longint CYCLE_CAP = 64'd40_000_000;
	localparam int     PHASES    = 14;
	localparam int     RAND_BEATS = 136;

	typedef struct {
		bit                 f;
		logic signed [31:0] x;
		logic signed [31:0] y;
		bit                 fixed;
		logic signed [31:0] ex;
		logic signed [31:0] ey;
		logic [1:0]         est;
	} beat_t;

	typedef struct {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic [1:0]         st;
	} point_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [ldm_pkg::PADDR_W-1:0] paddr = '0;
	logic [63:0] pwdata = '0;
	logic [63:0] prdata;
	logic pready;
	logic in_valid = 1'b0, in_ready;
	logic func = 1'b0;
	logic signed [31:0] in_x = '0, in_y = '0;
	logic out_valid, out_ready = 1'b0;
	logic signed [31:0] out_x, out_y;
	logic [1:0] status;

	logic [63:0] cfg_focal, cfg_centre;
	logic [31:0] cfg_skew, cfg_k1, cfg_k2, cfg_k3, cfg_p1, cfg_p2;
	bit sat_hit;
	point_t mapped_q[$];
	beat_t cur_beat;
	beat_t dir_rows[$];
	int errs = 0;
	longint cycles = 0;
	int burst_left = 0;
	int stall_run = 0;
	bit stall_lvl = 1'b1;

	lens_distortion_map i_dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_ready(in_ready), .func(func), .in_x(in_x), .in_y(in_y),
		.out_valid(out_valid), .out_ready(out_ready),
		.out_x(out_x), .out_y(out_y), .status(status)
	);

	always #1 clk = ~clk;

	function automatic longint clip(input longint v);
		if (v > S32_HI) begin
			sat_hit = 1'b1;
			return S32_HI;
		end
		if (v < S32_LO) begin
			sat_hit = 1'b1;
			return S32_LO;
		end
		return v;
	endfunction

	function automatic void lens_terms(input longint x, input longint y,
			output longint rad, output longint dx, output longint dy);
		longint k1, k2, k3, p1, p2, xx, yy, xy, r2, r4, r6, tx, ty;
		k1 = longint'($signed(cfg_k1));
		k2 = longint'($signed(cfg_k2));
		k3 = longint'($signed(cfg_k3));
		p1 = longint'($signed(cfg_p1));
		p2 = longint'($signed(cfg_p2));
		xx = (x * x) >>> 28;
		yy = (y * y) >>> 28;
		xy = clip((x * y) >>> 28);
		r2 = clip(xx + yy);
		r4 = clip((r2 * r2) >>> 28);
		r6 = clip((r4 * r2) >>> 28);
		tx = clip(r2 + 2 * xx);
		ty = clip(r2 + 2 * yy);
		rad = clip(ldm_pkg::Q28_ONE + ((k1 * r2) >>> 24) + ((k2 * r4) >>> 24)
			+ ((k3 * r6) >>> 24));
		dx = clip(2 * ((p1 * xy) >>> 24) + ((p2 * tx) >>> 24));
		dy = clip(((p1 * ty) >>> 24) + 2 * ((p2 * xy) >>> 24));
	endfunction

	function automatic point_t map_point(input bit f, input logic signed [31:0] x,
			input logic signed [31:0] y);
		point_t r;
		longint fx, fy, cx, cy, skew, ix, iy, rx, ry, rad, dx, dy;
		longint xn, yn, x0, y0, xd, yd, s;
		logic [1:0] st;
		fx = longint'({32'd0, cfg_focal[63:32]});
		fy = longint'({32'd0, cfg_focal[31:0]});
		cx = longint'($signed(cfg_centre[63:32]));
		cy = longint'($signed(cfg_centre[31:0]));
		skew = longint'($signed(cfg_skew));
		ix = longint'(x);
		iy = longint'(y);
		st = ldm_pkg::ST_OK;
		sat_hit = 1'b0;
		if (!f) begin
			if (fx < 1 || fy < 1) begin
				rx = clip(ix - cx);
				ry = clip(iy - cy);
				st = ldm_pkg::ST_FOCAL;
			end else begin
				yn = clip(((iy - cy) * ldm_pkg::Q28_ONE) / fy);
				xn = clip((((ix - cx) * ldm_pkg::Q28_ONE) / fx) - ((skew * yn) >>> 24));
				x0 = xn;
				y0 = yn;
				for (int i = 0; i < 20; i++) begin
					lens_terms(xn, yn, rad, dx, dy);
					if (rad > -longint'(ldm_pkg::RAD_EPS) &&
							rad < longint'(ldm_pkg::RAD_EPS)) begin
						st = ldm_pkg::ST_SING;
						break;
					end
					xn = clip((clip(x0 - dx) * ldm_pkg::Q28_ONE) / rad);
					yn = clip((clip(y0 - dy) * ldm_pkg::Q28_ONE) / rad);
				end
				rx = xn;
				ry = yn;
			end
		end else begin
			lens_terms(ix, iy, rad, dx, dy);
			xd = clip(((ix * rad) >>> 28) + dx);
			yd = clip(((iy * rad) >>> 28) + dy);
			s = clip(xd + ((skew * yd) >>> 24));
			rx = clip(((fx * s) >>> 28) + cx);
			ry = clip(((fy * yd) >>> 28) + cy);
		end
		if (st == ldm_pkg::ST_OK && sat_hit)
			st = ldm_pkg::ST_SAT;
		r.x = rx[31:0];
		r.y = ry[31:0];
		r.st = st;
		return r;
	endfunction

	always @(posedge clk) begin
		point_t e;
		cycles <= cycles + 1;
		if (cycles > CYCLE_CAP) begin
			$display("FAILURE");
			$finish;
		end
		if (in_valid && in_ready) begin
			if (cur_beat.fixed) begin
				e.x = cur_beat.ex;
				e.y = cur_beat.ey;
				e.st = cur_beat.est;
			end else begin
				e = map_point(cur_beat.f, cur_beat.x, cur_beat.y);
			end
			mapped_q = {mapped_q, e};
		end
		if (out_valid && out_ready) begin
			if (mapped_q.size() == 0) begin
				$error("unexpected beat x=%h y=%h status=%0d", out_x, out_y, status);
				errs++;
			end else begin
				e = mapped_q.pop_front();
				if (out_x !== e.x) begin
					$error("out_x expected %h actual %h", e.x, out_x);
					errs++;
				end
				if (out_y !== e.y) begin
					$error("out_y expected %h actual %h", e.y, out_y);
					errs++;
				end
				if (status !== e.st) begin
					$error("status expected %0d actual %0d", e.st, status);
					errs++;
				end
			end
		end
	end

	always @(negedge clk) begin
		case ((cycles >> 10) % 3)
			0: out_ready <= 1'b1;
			1: out_ready <= 1'($urandom_range(0, 1));
			default: begin
				if (stall_run == 0) begin
					stall_lvl = ~stall_lvl;
					stall_run = $urandom_range(1, 40);
				end
				stall_run--;
				out_ready <= stall_lvl;
			end
		endcase
	end

	task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
		@(negedge clk);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b1;
		paddr = ldm_pkg::PADDR_W'({idx, 3'b000});
		pwdata = val;
		@(negedge clk);
		penable = 1'b1;
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		case (idx)
			ldm_pkg::REG_FOCAL:  cfg_focal = val;
			ldm_pkg::REG_CENTRE: cfg_centre = val;
			ldm_pkg::REG_SKEW:   cfg_skew = val[31:0];
			ldm_pkg::REG_K1:     cfg_k1 = val[31:0];
			ldm_pkg::REG_K2:     cfg_k2 = val[31:0];
			ldm_pkg::REG_K3:     cfg_k3 = val[31:0];
			ldm_pkg::REG_P1:     cfg_p1 = val[31:0];
			default:             cfg_p2 = val[31:0];
		endcase
	endtask

	task automatic send_beat(input beat_t b);
		if (burst_left == 0) begin
			repeat ($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 30)) begin
				@(negedge clk);
				in_valid = 1'b0;
			end
			burst_left = $urandom_range(1, 12);
		end
		burst_left--;
		@(negedge clk);
		cur_beat = b;
		func = b.f;
		in_x = b.x;
		in_y = b.y;
		in_valid = 1'b1;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic drain();
		@(negedge clk);
		in_valid = 1'b0;
		while (mapped_q.size() != 0)
			@(posedge clk);
	endtask

	function automatic beat_t row(input bit f, input int x, input int y, input bit fixed = 0,
			input int ex = 0, input int ey = 0, input logic [1:0] est = ldm_pkg::ST_OK);
		beat_t b;
		b.f = f;
		b.x = x;
		b.y = y;
		b.fixed = fixed;
		b.ex = ex;
		b.ey = ey;
		b.est = est;
		return b;
	endfunction

	function automatic int span(input int s);
		return int'($urandom_range(0, 2 * s)) - s;
	endfunction

	function automatic beat_t rand_beat();
		beat_t b;
		b.f = 1'($urandom_range(0, 1));
		b.fixed = 1'b0;
		if ($urandom_range(0, 9) < 7) begin
			if (!b.f) begin
				b.x = $signed(cfg_centre[63:32]) + span(400 << 16);
				b.y = $signed(cfg_centre[31:0]) + span(400 << 16);
			end else begin
				b.x = span(32'h1800_0000);
				b.y = span(32'h1800_0000);
			end
		end else begin
			b.x = $urandom;
			b.y = $urandom;
		end
		return b;
	endfunction

	initial begin
		logic [63:0] v[8];
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		cfg_focal = 64'h0001_0000_0001_0000;
		cfg_centre = '0;
		{cfg_skew, cfg_k1, cfg_k2, cfg_k3, cfg_p1, cfg_p2} = '0;

		dir_rows = '{
			row(1, 0, 0, 1, 0, 0, ldm_pkg::ST_OK),
			row(1, 1 << 28, 0, 1, 65536, 0, ldm_pkg::ST_OK),
			row(0, 1 << 16, 2 << 16, 1, 1 << 28, 2 << 28, ldm_pkg::ST_SAT),
			row(1, 32'h7fff_ffff, 32'h7fff_ffff),
			row(1, 32'h8000_0000, 32'h8000_0000),
			row(0, 32'h7fff_ffff, 32'h8000_0000),
			row(0, 32'h8000_0000, 32'h7fff_ffff),
			row(1, -(1 << 28), 1 << 27),
			row(0, -(3 << 16), 5 << 15)
		};
		foreach (dir_rows[i])
			send_beat(dir_rows[i]);
		drain();

		for (int p = 0; p < PHASES; p++) begin
			dir_rows.delete();
			case (p)
				0: begin
					v = '{64'hffff_ffff_ffff_ffff, 64'h7fff_ffff_7fff_ffff, 64'h7fff_ffff,
						64'h7fff_ffff, 64'h7fff_ffff, 64'h7fff_ffff, 64'h7fff_ffff,
						64'h7fff_ffff};
					dir_rows = '{row(0, 32'h7fff_ffff, 32'h7fff_ffff),
						row(1, 32'h8000_0000, 32'h7fff_ffff), row(1, 1 << 28, 1 << 28)};
				end
				1: begin
					v = '{64'h0, 64'h8000_0000_8000_0000, 64'h8000_0000, 64'h8000_0000,
						64'h8000_0000, 64'h8000_0000, 64'h8000_0000, 64'h8000_0000};
					dir_rows = '{row(0, 32'h7fff_ffff, 32'h7fff_ffff),
						row(0, 0, 0), row(1, 1 << 28, -(1 << 28))};
				end
				2: begin
					v = '{64'h0001_0000_0001_0000, 64'h0, 64'h0, 64'hff00_0000,
						64'h0, 64'h0, 64'h0, 64'h0};
					dir_rows = '{row(0, 1 << 16, 0, 1, 1 << 28, 0, ldm_pkg::ST_SING),
						row(0, 0, 1 << 16), row(1, 1 << 28, 0)};
				end
				3: begin
					v = '{{32'h0, 32'h0100_0000}, 64'h0, 64'h0, 64'h0, 64'h0, 64'h0,
						64'h0, 64'h0};
					dir_rows = '{row(0, 5 << 16, 7 << 16)};
				end
				default: begin
					v[0] = ($urandom_range(0, 7) == 0) ? {$urandom, $urandom} :
						{32'($urandom_range(200 << 16, 3000 << 16)),
						 32'($urandom_range(200 << 16, 3000 << 16))};
					v[1] = {32'($urandom_range(0, 2000 << 16)),
						32'($urandom_range(0, 2000 << 16))};
					v[2] = 64'(unsigned'(span(1 << 20)));
					v[3] = 64'(unsigned'(span(1 << 23)));
					v[4] = 64'(unsigned'(span(1 << 22)));
					v[5] = 64'(unsigned'(span(1 << 21)));
					v[6] = 64'(unsigned'(span(1 << 20)));
					v[7] = 64'(unsigned'(span(1 << 20)));
				end
			endcase
			for (int r = 0; r < 8; r++)
				write_reg(3'(r), v[r]);
			foreach (dir_rows[i])
				send_beat(dir_rows[i]);
			repeat (RAND_BEATS)
				send_beat(rand_beat());
			drain();
		end

		repeat (200) @(posedge clk);
		if (errs == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
`default_nettype wire
